// ===== hw/rtl/irpwc_pkg.sv =====
// Shared types and constants for the IR pulse-width capture block.
// Used by ir_pulse_width_capture; depends on nothing.
`timescale 1ns / 1ps

package irpwc_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_INVERT = 2'd0;
  localparam logic [1:0] REG_POLL   = 2'd1;
  localparam logic [1:0] REG_IDLE   = 2'd2;

  localparam logic [14:0] RUN_SAT        = 15'd32000;
  localparam logic [9:0]  POLL_RESET     = 10'd50;
  localparam logic [14:0] IDLE_RESET     = 15'd10000;

  typedef struct packed {
    logic [1:0] kind;
    logic       pin_level;
    logic [6:0] read_index;
  } item_t;

  typedef struct packed {
    logic               entry_written;
    logic [6:0]         entry_index;
    logic signed [15:0] entry_value;
    logic               message_complete;
    logic [6:0]         symbol_count;
  } result_t;

endpackage

// ===== hw/rtl/ir_pulse_width_capture.sv =====
// IR pulse-width capture: run timing, duration store and APB registers.
// Depends on irpwc_pkg.
// Each issued item gives a registered result beat; one item per cycle sustained unless the result side stalls.
// A tick updates run state in flops and writes the store in the same cycle;
// a read issues to the store and the registered read data forms the result.
// Reset clears run state, registers and handshakes; store contents stay
// undefined until written, with no clearing pass.
`timescale 1ns / 1ps

module ir_pulse_width_capture #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  irpwc_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output irpwc_pkg::result_t  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int IW = (AW > 7) ? AW : 7;
  localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_DEPTH - 1);

  // configuration
  logic        invert_input;
  logic [9:0]  poll_interval_us;
  logic [14:0] idle_threshold_us;
  logic        cfg_write;

  // run state
  logic [14:0]   run_time;
  logic [14:0]   run_time_next;
  logic          last_level;
  logic          last_level_next;
  logic [AW-1:0] write_position;
  logic [AW-1:0] write_position_next;
  logic          complete_flag;
  logic          complete_flag_next;

  // handshake
  logic             skid_valid;
  irpwc_pkg::item_t skid;
  irpwc_pkg::item_t src;
  logic             src_valid;
  logic             issue;
  logic             item_accept;

  // tick datapath
  logic               level;
  logic               idle_end;
  logic               changed;
  logic               wr_en;
  logic signed [15:0] wr_value;
  logic [15:0]        run_sum;
  logic [14:0]        run_base;

  // read datapath
  logic [IW:0]   ridx_ext;
  logic          rd_in_range;
  logic          rd_en;
  logic [AW-1:0] raddr;

  // store and result stage
  logic signed [15:0] mem [BUFFER_DEPTH];
  logic signed [15:0] rd_q;
  logic               rd_sel;
  irpwc_pkg::result_t res_q;
  irpwc_pkg::result_t res_next;

  // APB
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_input      <= 1'b0;
      poll_interval_us  <= irpwc_pkg::POLL_RESET;
      idle_threshold_us <= irpwc_pkg::IDLE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        irpwc_pkg::REG_INVERT: invert_input      <= pwdata[0];
        irpwc_pkg::REG_POLL:   poll_interval_us  <= pwdata[9:0];
        irpwc_pkg::REG_IDLE:   idle_threshold_us <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      irpwc_pkg::REG_INVERT: prdata = {31'd0, invert_input};
      irpwc_pkg::REG_POLL:   prdata = {22'd0, poll_interval_us};
      irpwc_pkg::REG_IDLE:   prdata = {17'd0, idle_threshold_us};
      default:               prdata = 32'd0;
    endcase
  end

  // input skid and issue
  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !skid_valid;
  assign src_valid   = skid_valid || item_valid;
  assign src         = skid_valid ? skid : item;
  assign issue       = src_valid && !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (item_accept && !issue) begin
      skid_valid <= 1'b1;
    end else if (issue) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && !issue) begin
      skid <= item;
    end
  end

  // tick evaluation
  assign level    = src.pin_level ^ invert_input;
  assign idle_end = (run_time > idle_threshold_us) && !level && (write_position != '0);
  assign changed  = level != last_level;
  assign wr_value = last_level ? signed'({1'b0, run_time})
                               : signed'(16'd0 - {1'b0, run_time});
  assign run_base = (changed && !idle_end) ? 15'd0 : run_time;
  assign run_sum  = 16'(run_base) + 16'(poll_interval_us);

  assign ridx_ext    = (IW+1)'(src.read_index);
  assign rd_in_range = ridx_ext < (IW+1)'(BUFFER_DEPTH);
  assign raddr       = ridx_ext[AW-1:0];

  always_comb begin
    run_time_next       = run_time;
    last_level_next     = last_level;
    write_position_next = write_position;
    complete_flag_next  = complete_flag;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    res_next            = '0;
    unique case (src.kind)
      irpwc_pkg::KIND_TICK: begin
        if (changed || idle_end) begin
          wr_en                  = 1'b1;
          res_next.entry_written = 1'b1;
          res_next.entry_index   = 7'(write_position);
          res_next.entry_value   = wr_value;
          if (idle_end) begin
            complete_flag_next = 1'b1;
          end else begin
            last_level_next = level;
            if (write_position != LAST_POS) begin
              write_position_next = write_position + AW'(1);
            end
          end
        end
        run_time_next = (run_sum > 16'(irpwc_pkg::RUN_SAT)) ? irpwc_pkg::RUN_SAT
                                                            : run_sum[14:0];
      end
      irpwc_pkg::KIND_CLEAR: begin
        write_position_next = '0;
        last_level_next     = 1'b0;
        complete_flag_next  = 1'b0;
      end
      irpwc_pkg::KIND_READ: begin
        rd_en                = rd_in_range;
        res_next.entry_index = src.read_index;
      end
      default: ;
    endcase
    res_next.message_complete = complete_flag_next;
    res_next.symbol_count     = 7'(write_position_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_time       <= 15'd0;
      last_level     <= 1'b0;
      write_position <= '0;
      complete_flag  <= 1'b0;
    end else if (issue) begin
      run_time       <= run_time_next;
      last_level     <= last_level_next;
      write_position <= write_position_next;
      complete_flag  <= complete_flag_next;
    end
  end

  // duration store
  always_ff @(posedge clk) begin
    if (issue && wr_en) begin
      mem[write_position] <= wr_value;
    end
    if (issue && rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (issue) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      res_q  <= res_next;
      rd_sel <= rd_en;
    end
  end

  always_comb begin
    result             = res_q;
    result.entry_value = rd_sel ? rd_q : res_q.entry_value;
  end

  // checks
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    write_position <= LAST_POS)
    else $error("write position past last slot");

  a_run_sat: assert property (@(posedge clk) disable iff (rst)
    run_time <= irpwc_pkg::RUN_SAT)
    else $error("run time above saturation");

  a_flag_pos: assert property (@(posedge clk) disable iff (rst)
    complete_flag |-> write_position != '0)
    else $error("message complete with no stored run");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    issue && src.kind == irpwc_pkg::KIND_CLEAR |=>
      write_position == '0 && !complete_flag && !last_level)
    else $error("clear did not reset capture position");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid filled while result side was free");

endmodule
